/* rtl/pmm_pkg.sv */
package pmm_pkg;

  // Field widths of the ports
  localparam int COEF_W = 32;
  localparam int IDX_W  = 9;
  localparam int DEG_W  = 8;
  localparam int MODE_W = 2;

  // Store geometry
  localparam int MAX_DEGREE = 255;
  localparam int OP_DEPTH   = MAX_DEGREE + 1;
  localparam int PROD_DEPTH = 2 * MAX_DEGREE + 1;
  localparam int OP_AW      = $clog2(OP_DEPTH);
  localparam int PROD_AW    = $clog2(PROD_DEPTH);
  localparam int FILL_W     = $clog2(PROD_DEPTH + 1);

  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD    = 2'd0,
    MODE_COMPUTE = 2'd1,
    MODE_READ    = 2'd2
  } mode_t;

  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_RANGE = 1'b1;

  // One multiply-accumulate term issued by the sequencer
  typedef struct packed {
    logic               vld;
    logic               first;   // first term of coefficient k
    logic               last;    // last term of coefficient k
    logic [PROD_AW-1:0] k;
    logic [OP_AW-1:0]   p_addr;
    logic [OP_AW-1:0]   q_addr;
  } iss_t;

  // Datapath status back to the controller
  typedef struct packed {
    logic idle;     // no term in flight
    logic prod_we;  // product store written this cycle
  } mac_stat_t;

endpackage

/* rtl/pmm_ram.sv */
module pmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* rtl/pmm_seq.sv */
module pmm_seq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [pmm_pkg::OP_AW-1:0]  n,
  output pmm_pkg::iss_t              iss,
  output logic                       busy
);
  import pmm_pkg::*;

  // Walks k = 0..2n, and for each k the index i over max(0,k-n)..min(k,n).
  logic               busy_r, busy_nxt;
  logic               first_r, first_nxt;
  logic [PROD_AW-1:0] k_r, k_nxt;
  logic [OP_AW-1:0]   i_r, i_nxt;
  logic [OP_AW-1:0]   n_r, n_nxt;

  logic [PROD_AW-1:0] n_ext;
  logic [PROD_AW-1:0] two_n;
  logic [PROD_AW-1:0] k_inc;
  logic [OP_AW-1:0]   i_hi;
  logic [OP_AW-1:0]   i_lo_next;
  logic               last_term;

  always_comb begin
    n_ext     = PROD_AW'(n_r);
    two_n     = PROD_AW'({n_r, 1'b0});
    k_inc     = k_r + PROD_AW'(1);
    i_hi      = (k_r < n_ext) ? OP_AW'(k_r) : n_r;
    i_lo_next = (k_inc > n_ext) ? OP_AW'(k_inc - n_ext) : '0;
    last_term = (i_r == i_hi);
  end

  always_comb begin
    busy_nxt  = busy_r;
    first_nxt = first_r;
    k_nxt     = k_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    if (start) begin
      busy_nxt  = 1'b1;
      first_nxt = 1'b1;
      k_nxt     = '0;
      i_nxt     = '0;
      n_nxt     = n;
    end else if (busy_r) begin
      if (last_term) begin
        if (k_r == two_n) begin
          busy_nxt = 1'b0;
        end else begin
          k_nxt     = k_inc;
          i_nxt     = i_lo_next;
          first_nxt = 1'b1;
        end
      end else begin
        i_nxt     = i_r + OP_AW'(1);
        first_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    first_r <= first_nxt;
    k_r     <= k_nxt;
    i_r     <= i_nxt;
    n_r     <= n_nxt;
  end

  always_comb begin
    iss.vld    = busy_r;
    iss.first  = first_r;
    iss.last   = last_term;
    iss.k      = k_r;
    iss.p_addr = i_r;
    iss.q_addr = OP_AW'(k_r - PROD_AW'(i_r));
  end

  assign busy = busy_r;

endmodule

/* rtl/pmm_mac.sv */
module pmm_mac (
  input  logic                         clk,
  input  logic                         rst_n,
  // operand load
  input  logic                         ld_en,
  input  logic [pmm_pkg::OP_AW-1:0]    ld_addr,
  input  logic [pmm_pkg::COEF_W-1:0]   ld_p,
  input  logic [pmm_pkg::COEF_W-1:0]   ld_q,
  // term stream from the sequencer
  input  pmm_pkg::iss_t                iss,
  // product read
  input  logic [pmm_pkg::PROD_AW-1:0]  rd_addr,
  output logic [pmm_pkg::COEF_W-1:0]   rd_data,
  output pmm_pkg::mac_stat_t           stat
);
  import pmm_pkg::*;

  // Operand entries never loaded read as zero.
  logic [OP_DEPTH-1:0] opv_r, opv_nxt;

  logic [COEF_W-1:0] p_rd, q_rd;
  logic [COEF_W-1:0] p_op, q_op;

  iss_t              s1_r, s2_r;
  logic              p_v1_r, q_v1_r;
  logic [COEF_W-1:0] mult_r;
  logic [COEF_W-1:0] acc_r;
  logic [COEF_W-1:0] acc_sum;
  logic              prod_we;

  pmm_ram #(.WIDTH(COEF_W), .DEPTH(OP_DEPTH)) u_p_ram (
    .clk   (clk),
    .we    (ld_en),
    .waddr (ld_addr),
    .wdata (ld_p),
    .raddr (iss.p_addr),
    .rdata (p_rd)
  );

  pmm_ram #(.WIDTH(COEF_W), .DEPTH(OP_DEPTH)) u_q_ram (
    .clk   (clk),
    .we    (ld_en),
    .waddr (ld_addr),
    .wdata (ld_q),
    .raddr (iss.q_addr),
    .rdata (q_rd)
  );

  always_comb begin
    opv_nxt = opv_r;
    if (ld_en) begin
      opv_nxt[ld_addr] = 1'b1;
    end
  end

  assign p_op = p_v1_r ? p_rd : '0;
  assign q_op = q_v1_r ? q_rd : '0;

  assign acc_sum = s2_r.first ? mult_r : acc_r + mult_r;
  assign prod_we = s2_r.vld && s2_r.last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      opv_r    <= '0;
      s1_r.vld <= 1'b0;
      s2_r.vld <= 1'b0;
    end else begin
      opv_r    <= opv_nxt;
      s1_r.vld <= iss.vld;
      s2_r.vld <= s1_r.vld;
    end
    // stage 1: operand read
    s1_r.first  <= iss.first;
    s1_r.last   <= iss.last;
    s1_r.k      <= iss.k;
    s1_r.p_addr <= iss.p_addr;
    s1_r.q_addr <= iss.q_addr;
    p_v1_r      <= opv_r[iss.p_addr];
    q_v1_r      <= opv_r[iss.q_addr];
    // stage 2: low word of the product
    s2_r.first  <= s1_r.first;
    s2_r.last   <= s1_r.last;
    s2_r.k      <= s1_r.k;
    s2_r.p_addr <= s1_r.p_addr;
    s2_r.q_addr <= s1_r.q_addr;
    mult_r      <= p_op * q_op;
    // accumulate
    if (s2_r.vld) begin
      acc_r <= acc_sum;
    end
  end

  pmm_ram #(.WIDTH(COEF_W), .DEPTH(PROD_DEPTH)) u_prod_ram (
    .clk   (clk),
    .we    (prod_we),
    .waddr (s2_r.k),
    .wdata (acc_sum),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_comb begin
    stat.idle    = !iss.vld && !s1_r.vld && !s2_r.vld;
    stat.prod_we = prod_we;
  end

endmodule

/* rtl/poly_mul_mod2_32.sv */
// Channel  | Handshake              | Payload
// ---------+------------------------+-------------------------------------------
// input    | in_valid / in_ready    | in_mode, in_index, in_p_coef, in_q_coef
// result   | out_valid / out_ready  | out_status, out_product_coef
// config   | cfg_we (no wait)       | cfg_wdata (degree)
//
// Load: accept, then hold. Read: accept, registered product store read, then hold.
// Compute: the (n+1)^2 terms run on the one 32x32 multiply-accumulate unit,
//   then the read/multiply/accumulate pipe drains before the hand-off.
// Reset (rst_n low, synchronous) clears degree, the operand valid bits and the
//   product fill count; no clearing pass over the stores.
// The result sits in a hold register until the output register is free, so a
//   stalled out_ready delays the next accept but never loses a result.
module poly_mul_mod2_32 (
  input  logic                         clk,
  input  logic                         rst_n,
  // input transactions
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pmm_pkg::MODE_W-1:0]   in_mode,
  input  logic [pmm_pkg::IDX_W-1:0]    in_index,
  input  logic [pmm_pkg::COEF_W-1:0]   in_p_coef,
  input  logic [pmm_pkg::COEF_W-1:0]   in_q_coef,
  // result transactions
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_status,
  output logic [pmm_pkg::COEF_W-1:0]   out_product_coef,
  // degree register
  input  logic                         cfg_we,
  input  logic [pmm_pkg::DEG_W-1:0]    cfg_wdata
);
  import pmm_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_COMPUTE,
    ST_HOLD
  } state_t;

  state_t             state_r, state_nxt;
  logic [DEG_W-1:0]   degree_r;

  // Entries below the fill count were written by the last compute;
  // the rest read as zero.
  logic [FILL_W-1:0]  fill_r, fill_nxt;

  logic               hold_status_r, hold_status_nxt;
  logic [COEF_W-1:0]  hold_coef_r, hold_coef_nxt;
  logic               rd_live_r, rd_live_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_status_r, out_status_nxt;
  logic [COEF_W-1:0]  out_coef_r, out_coef_nxt;

  logic [OP_AW-1:0]   eff_n;
  logic [IDX_W:0]     idx_ext;
  logic [IDX_W:0]     n_ext;
  logic [IDX_W:0]     two_n_ext;
  logic               accept;
  logic               ld_ok;
  logic               rd_ok;
  logic               ld_en;
  logic               seq_start;
  logic               seq_busy;
  logic               out_free;

  iss_t               iss;
  mac_stat_t          mstat;
  logic [COEF_W-1:0]  prod_rd;

  // degree saturates at the store size
  always_comb begin
    if (int'(degree_r) > MAX_DEGREE) begin
      eff_n = OP_AW'(MAX_DEGREE);
    end else begin
      eff_n = OP_AW'(degree_r);
    end
  end

  assign idx_ext   = (IDX_W + 1)'(in_index);
  assign n_ext     = (IDX_W + 1)'(eff_n);
  assign two_n_ext = (IDX_W + 1)'({eff_n, 1'b0});
  assign ld_ok     = (idx_ext <= n_ext);
  assign rd_ok     = (idx_ext <= two_n_ext);

  assign in_ready  = (state_r == ST_IDLE);
  assign accept    = in_valid && in_ready;
  assign ld_en     = accept && (mode_t'(in_mode) == MODE_LOAD) && ld_ok;
  assign seq_start = accept && (mode_t'(in_mode) == MODE_COMPUTE);
  assign out_free  = !out_valid_r || out_ready;

  pmm_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (seq_start),
    .n     (eff_n),
    .iss   (iss),
    .busy  (seq_busy)
  );

  pmm_mac u_mac (
    .clk     (clk),
    .rst_n   (rst_n),
    .ld_en   (ld_en),
    .ld_addr (OP_AW'(in_index)),
    .ld_p    (in_p_coef),
    .ld_q    (in_q_coef),
    .iss     (iss),
    .rd_addr (PROD_AW'(in_index)),
    .rd_data (prod_rd),
    .stat    (mstat)
  );

  always_comb begin
    state_nxt       = state_r;
    fill_nxt        = fill_r;
    hold_status_nxt = hold_status_r;
    hold_coef_nxt   = hold_coef_r;
    rd_live_nxt     = rd_live_r;
    out_valid_nxt   = out_valid_r;
    out_status_nxt  = out_status_r;
    out_coef_nxt    = out_coef_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          hold_status_nxt = STATUS_OK;
          hold_coef_nxt   = '0;
          case (mode_t'(in_mode))
            MODE_LOAD: begin
              hold_status_nxt = ld_ok ? STATUS_OK : STATUS_RANGE;
              state_nxt       = ST_HOLD;
            end
            MODE_COMPUTE: begin
              fill_nxt  = FILL_W'({eff_n, 1'b0}) + FILL_W'(1);
              state_nxt = ST_COMPUTE;
            end
            MODE_READ: begin
              hold_status_nxt = rd_ok ? STATUS_OK : STATUS_RANGE;
              rd_live_nxt     = rd_ok && ((FILL_W + 1)'(in_index) < (FILL_W + 1)'(fill_r));
              state_nxt       = ST_READ;
            end
            default: begin
              state_nxt = ST_HOLD;
            end
          endcase
        end
      end
      ST_READ: begin
        hold_coef_nxt = rd_live_r ? prod_rd : '0;
        state_nxt     = ST_HOLD;
      end
      ST_COMPUTE: begin
        if (!seq_busy && mstat.idle) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = hold_status_r;
          out_coef_nxt   = hold_coef_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      degree_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        degree_r <= cfg_wdata;
      end
    end
    hold_status_r <= hold_status_nxt;
    hold_coef_r   <= hold_coef_nxt;
    rd_live_r     <= rd_live_nxt;
    out_status_r  <= out_status_nxt;
    out_coef_r    <= out_coef_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_product_coef = out_coef_r;

`ifndef SYNTHESIS
  // product store is only written while a compute is running
  a_prod_we_in_compute: assert property (@(posedge clk) disable iff (!rst_n)
    mstat.prod_we |-> (state_r == ST_COMPUTE))
    else $error("product store written outside compute");

  // sequencer issues terms only during a compute
  a_seq_in_compute: assert property (@(posedge clk) disable iff (!rst_n)
    seq_busy |-> (state_r == ST_COMPUTE))
    else $error("term issued outside compute");

  // an accepted transaction drops input ready in the next cycle
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input ready right after accept");

  // a result leaves the hold state only into a free output register
  a_hold_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD) && out_free |=> out_valid_r && (out_status_r == $past(hold_status_r)))
    else $error("held result not delivered");
`endif

endmodule

/* tb/tb_poly_mul_mod2_32.sv */
`timescale 1ns / 1ps

module tb_poly_mul_mod2_32;
  import pmm_pkg::*;

  // Mode 3 is unused by the block: no action, status ok, coefficient 0
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  // Worst case is dominated by the two large computes (256^2 and 201^2 MAC
  // terms) plus ~700 transactions each waiting out a long gap and a long
  // result stall; this is several times that.
  localparam int CYCLE_LIMIT  = 1_200_000;
  localparam int TAIL_CYCLES  = 32;
  localparam int RANDOM_ITEMS = 600;
  localparam int MAX_RAND_DEG = 31;   // keeps random computes short

  typedef struct packed {
    logic              status;
    logic [COEF_W-1:0] coef;
  } poly_result_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [MODE_W-1:0] in_mode   = MODE_SPARE;
  logic [IDX_W-1:0]  in_index  = '0;
  logic [COEF_W-1:0] in_p_coef = '0;
  logic [COEF_W-1:0] in_q_coef = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic              out_status;
  logic [COEF_W-1:0] out_product_coef;
  logic              cfg_we    = 1'b0;
  logic [DEG_W-1:0]  cfg_wdata = '0;

  // Shadow copies of the operand/product stores and the degree register
  logic [COEF_W-1:0] p_shadow    [OP_DEPTH];
  logic [COEF_W-1:0] q_shadow    [OP_DEPTH];
  logic [COEF_W-1:0] prod_shadow [PROD_DEPTH];
  int unsigned       deg_shadow;

  // Results still owed by the block, oldest first
  poly_result_t awaited_results[$];

  int err_cnt    = 0;
  int cycle_cnt  = 0;
  int items_sent = 0;
  int stall_left = 0;
  bit in_gaps_on    = 1'b1;
  bit out_stalls_on = 1'b1;

  poly_mul_mod2_32 u_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_index         (in_index),
    .in_p_coef        (in_p_coef),
    .in_q_coef        (in_q_coef),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_product_coef (out_product_coef),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t ns: cycle limit reached, %0d results still awaited",
               $time, awaited_results.size());
      $display("** poly_mul_mod2_32: FAILED **");
      $finish;
    end
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50)      return 0;
    else if (r < 88) return $urandom_range(1, 3);
    else             return $urandom_range(8, 40);
  endfunction

  // Coefficients biased toward zero, all-ones and tiny values so that the
  // mod 2^32 wrap of products and of sums gets hit often
  function automatic logic [COEF_W-1:0] pick_coef();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10)      return '0;
    else if (r < 20) return '1;
    else if (r < 30) return $urandom_range(0, 15);
    else             return $urandom();
  endfunction

  // Mostly in range [0, lim], sometimes anywhere in the 9-bit field
  function automatic logic [IDX_W-1:0] pick_index(input int unsigned lim);
    if ($urandom_range(0, 9) != 0) return IDX_W'($urandom_range(0, lim));
    else                           return IDX_W'($urandom_range(0, 511));
  endfunction

  // Expected result of one transaction; updates the shadow stores as the block
  // would. Compute clears the whole product store, then forms the
  // convolution over coefficients 0..n, every term and sum truncated to 32 bits.
  function automatic poly_result_t predict_product_item(
    input logic [MODE_W-1:0] mode,
    input logic [IDX_W-1:0]  idx,
    input logic [COEF_W-1:0] pc,
    input logic [COEF_W-1:0] qc
  );
    poly_result_t res;
    int unsigned  n;
    res        = '0;
    res.status = STATUS_OK;
    n = (deg_shadow > MAX_DEGREE) ? MAX_DEGREE : deg_shadow;
    case (mode)
      MODE_LOAD: begin
        if (idx <= n) begin
          p_shadow[idx] = pc;
          q_shadow[idx] = qc;
        end else begin
          res.status = STATUS_RANGE;
        end
      end
      MODE_COMPUTE: begin
        foreach (prod_shadow[k]) prod_shadow[k] = '0;
        for (int i = 0; i <= n; i++)
          for (int j = 0; j <= n; j++)
            prod_shadow[i + j] = prod_shadow[i + j] + p_shadow[i] * q_shadow[j];
      end
      MODE_READ: begin
        // stale products stay readable until the next compute
        if (idx <= 2 * n) res.coef = prod_shadow[idx];
        else              res.status = STATUS_RANGE;
      end
      default: ;
    endcase
    return res;
  endfunction

  // One input transaction. Called at a rising edge; returns at the edge that
  // accepted it, with in_valid still high so a back-to-back item needs no
  // drop. The expectation is formed at acceptance.
  task automatic send_item(
    input logic [MODE_W-1:0] mode,
    input logic [IDX_W-1:0]  idx,
    input logic [COEF_W-1:0] pc,
    input logic [COEF_W-1:0] qc
  );
    int gap;
    gap = in_gaps_on ? idle_len() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_mode   <= mode;
    in_index  <= idx;
    in_p_coef <= pc;
    in_q_coef <= qc;
    do @(posedge clk); while (in_ready !== 1'b1);
    awaited_results.push_back(predict_product_item(mode, idx, pc, qc));
    items_sent++;
  endtask

  // Degree write only once the block is idle: every transaction yields a
  // result, so an empty queue means nothing is in flight.
  task automatic set_degree(input int unsigned d);
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= d[DEG_W-1:0];
    @(posedge clk);
    cfg_we     <= 1'b0;
    deg_shadow = d;
  endtask

  // Result side: random back-pressure, switched off for some phases
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (out_stalls_on && $urandom_range(0, 99) < 20) begin
      stall_left = idle_len();
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Scoreboard: each result transaction against the oldest expectation
  always @(posedge clk) begin : result_check
    poly_result_t want;
    if (rst_n && out_valid === 1'b1 && out_ready) begin
      if (awaited_results.size() == 0) begin
        $display("%0t ns: unexpected result, status %0d product_coef %h",
                 $time, out_status, out_product_coef);
        err_cnt++;
      end else begin
        want = awaited_results.pop_front();
        if (out_status !== want.status) begin
          $display("%0t ns: status mismatch, expected %0d actual %0d",
                   $time, want.status, out_status);
          err_cnt++;
        end
        if (out_product_coef !== want.coef) begin
          $display("%0t ns: product_coef mismatch, expected %h actual %h",
                   $time, want.coef, out_product_coef);
          err_cnt++;
        end
      end
    end
  end

  // Degree 0 straight out of reset: product store reads zero before any
  // compute, index 1 is already out of range, unloaded operands count as zero.
  task automatic test_reset_state();
    send_item(MODE_READ,    9'd0, '0, '0);
    send_item(MODE_READ,    9'd1, '0, '0);
    send_item(MODE_LOAD,    9'd1, 32'h1234_5678, 32'h9abc_def0);
    send_item(MODE_COMPUTE, 9'd0, '0, '0);
    send_item(MODE_READ,    9'd0, '0, '0);
  endtask

  // All-ones operands: (2^32-1)^2 mod 2^32 = 1. The spare mode is sent with
  // every field bit set; a read at index 510 is out of range.
  task automatic test_coef_extremes();
    set_degree(0);
    send_item(MODE_LOAD,    9'd0,   '1, '1);
    send_item(MODE_COMPUTE, 9'd0,   '0, '0);
    send_item(MODE_READ,    9'd0,   '0, '0);
    send_item(MODE_SPARE,   9'd511, '1, '1);
    send_item(MODE_READ,    9'd510, '0, '0);
  endtask

  // Largest degree: load at the ends and the middle, loads past the top
  // are rejected, one full 256x256 compute, reads up to 511 (511 out of range).
  task automatic test_full_degree();
    set_degree(MAX_DEGREE);
    send_item(MODE_LOAD,    9'd0,   '1, '1);
    send_item(MODE_LOAD,    9'd255, '1, 32'd2);
    send_item(MODE_LOAD,    9'd128, $urandom(), $urandom());
    send_item(MODE_LOAD,    9'd256, '1, '1);
    send_item(MODE_LOAD,    9'd511, '1, '1);
    send_item(MODE_COMPUTE, 9'd0,   '0, '0);
    send_item(MODE_READ,    9'd0,   '0, '0);
    send_item(MODE_READ,    9'd255, '0, '0);
    send_item(MODE_READ,    9'd383, '0, '0);
    send_item(MODE_READ,    9'd510, '0, '0);
    send_item(MODE_READ,    9'd511, '0, '0);
  endtask

  // Shrink the degree without recomputing: in-range reads still return the
  // products of the degree-255 compute, the range check follows the new degree.
  task automatic test_stale_results();
    set_degree(2);
    send_item(MODE_READ, 9'd3,   '0, '0);
    send_item(MODE_READ, 9'd5,   '0, '0);
    send_item(MODE_LOAD, 9'd2,   $urandom(), $urandom());
    send_item(MODE_LOAD, 9'd3,   $urandom(), $urandom());
    send_item(MODE_READ, 9'd4,   '0, '0);
  endtask

  task automatic send_mixed_item(input int unsigned d);
    int r;
    r = $urandom_range(0, 99);
    if (r < 35)
      send_item(MODE_LOAD, pick_index(d), pick_coef(), pick_coef());
    else if (r < 70)
      send_item(MODE_READ, pick_index(2 * d), pick_coef(), pick_coef());
    else if (r < 80)
      send_item(MODE_COMPUTE, IDX_W'($urandom_range(0, 511)), pick_coef(), pick_coef());
    else if (r < 86)
      send_item(MODE_LOAD, IDX_W'($urandom_range(d + 1, 511)), pick_coef(), pick_coef());
    else if (r < 92)
      send_item(MODE_READ, IDX_W'($urandom_range(2 * d + 1, 511)), pick_coef(),
                pick_coef());
    else
      send_item(MODE_SPARE, IDX_W'($urandom_range(0, 511)), pick_coef(), pick_coef());
  endtask

  // Phases at random small degrees. Most start with a full load, a compute
  // and a read-back of every product; then a burst of mixed and broken items.
  // Some phases run with no idling on either side.
  task automatic test_random_phases();
    int          stop_at;
    int          r;
    int unsigned d;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      r = $urandom_range(0, 99);
      d = (r < 60) ? $urandom_range(0, 7) : $urandom_range(8, MAX_RAND_DEG);
      set_degree(d);
      in_gaps_on    = ($urandom_range(0, 3) != 0);
      out_stalls_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 9) < 7) begin
        for (int k = 0; k <= d; k++)
          send_item(MODE_LOAD, IDX_W'(k), pick_coef(), pick_coef());
        send_item(MODE_COMPUTE, IDX_W'($urandom_range(0, 511)), pick_coef(), pick_coef());
        for (int k = 0; k <= 2 * d; k++)
          send_item(MODE_READ, IDX_W'(k), pick_coef(), pick_coef());
      end
      repeat ($urandom_range(10, 30)) send_mixed_item(d);
    end
  endtask

  // One more long compute at a large degree, sparse loads on top of
  // whatever earlier phases left in the operand stores.
  task automatic test_large_degree();
    set_degree(200);
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    repeat (20) send_item(MODE_LOAD, IDX_W'($urandom_range(0, 200)), pick_coef(),
                          pick_coef());
    send_item(MODE_LOAD, 9'd201, pick_coef(), pick_coef());
    send_item(MODE_COMPUTE, 9'd0, '0, '0);
    repeat (20) send_item(MODE_READ, IDX_W'($urandom_range(0, 400)), '0, '0);
    send_item(MODE_READ, 9'd400, '0, '0);
    send_item(MODE_READ, 9'd401, '0, '0);
  endtask

  initial begin
    foreach (p_shadow[k]) begin
      p_shadow[k] = '0;
      q_shadow[k] = '0;
    end
    foreach (prod_shadow[k]) prod_shadow[k] = '0;
    deg_shadow = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_coef_extremes();
    test_full_degree();
    test_stale_results();
    test_random_phases();
    test_large_degree();

    // drain, then give the block time to show any stray result
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (err_cnt == 0)
      $display("** poly_mul_mod2_32: PASSED **");
    else
      $display("** poly_mul_mod2_32: FAILED **");
    $finish;
  end

endmodule

/* sim.f */
rtl/pmm_pkg.sv
rtl/pmm_ram.sv
rtl/pmm_seq.sv
rtl/pmm_mac.sv
rtl/poly_mul_mod2_32.sv
tb/tb_poly_mul_mod2_32.sv
